FILE: hdl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the rgb to hsv converter
// Word layouts of both channels, divider widths and hue scaling constants.
// ----------------------------------------------------------------------------
package rth_pkg;

   // field widths
   localparam int CHAN_W = 8;
   localparam int HUE_W  = 15;
   localparam int SAT_W  = 16;

   // hue scale: a sixth, green and blue bases, full circle; 1/64 degree units
   localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
   localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
   localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
   localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

   // reciprocal divider widths
   localparam int DIV_W      = CHAN_W;
   localparam int DIV_STAGES = 4;
   localparam int HUE_NUM_W  = 20;
   localparam int HUE_QUO_W  = 12;
   localparam int SAT_NUM_W  = 24;
   localparam int SAT_QUO_W  = 16;

   // pipeline depth from input register to output register
   localparam int PIPE_STAGES = DIV_STAGES + 2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rth_req_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [SAT_W-1:0]  saturation;
      logic [CHAN_W-1:0] brightness;
   } rth_rsp_type;

   // which channel holds the maximum
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } rth_sector_type;

   // per-stage load enables handed to the divider
   typedef struct packed {
      logic [DIV_STAGES-1:0] en;
   } rth_div_ctrl_type;

endpackage

FILE: hdl/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv: 8-bit rgb pixel to fixed point hue, saturation and value
// Streaming converter, one pixel word per clock while rsp_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   req_word carries red, green and blue; a word is taken when req_valid is
//   high and req_stall is low. rsp_word carries hue (1/64 degree, 0..23039),
//   saturation (65535 = 1.0) and brightness (largest channel).
//   Six register stages: one for max, min and chroma, four in each reciprocal
//   divider (table, multiply, back multiply, correction), one for hue
//   assembly and the output. The first stage loads at the accepting edge, and
//   rsp_valid rises when the word reaches the output register.
//   One word per cycle while rsp_stall is low; the divider pipelines set the depth.
//   Every stage loads whenever it is empty or the stage after it moves, so
//   bubbles close up and req_stall rises only when all six stages are full
//   and rsp_stall holds the output word.
//   Reset clears the valid bits only; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rgb_to_hsv (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rth_pkg::rth_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rth_pkg::rth_rsp_type rsp_word
);
   import rth_pkg::*;

   typedef struct packed {
      rth_sector_type    sector;
      logic              neg;
      logic [CHAN_W-1:0] mx;
   } rth_side_type;

   logic [PIPE_STAGES-1:0] valid_ff, valid_in;
   logic [PIPE_STAGES-1:0] en;

   logic [CHAN_W-1:0] mx_ff, chroma_ff, mag_ff;
   logic              neg_ff;
   rth_sector_type    sector_ff;

   logic [CHAN_W-1:0] mx_in, mn_in, chroma_in, mag_in;
   logic              neg_in;
   rth_sector_type    sector_in;

   rth_side_type      side_ff [DIV_STAGES];

   logic [HUE_NUM_W-1:0] hue_num;
   logic [SAT_NUM_W-1:0] sat_num;
   logic [HUE_QUO_W-1:0] hue_part;
   logic [SAT_QUO_W-1:0] sat_quo;
   rth_div_ctrl_type     div_ctrl;

   logic [HUE_W-1:0] hue_base, hue_in;
   rth_rsp_type      rsp_ff, rsp_in;

   // load enables: a stage moves when empty or when the next one moves
   always_comb begin
      en[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || !rsp_stall;
      for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_stall   = !en[0];
   assign div_ctrl.en = en[DIV_STAGES:1];

   // valid bits travel with the word
   always_comb begin
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < PIPE_STAGES; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // max, min, chroma and the signed difference of the other two channels
   always_comb begin
      mx_in = req_word.red;
      if (req_word.green > mx_in) mx_in = req_word.green;
      if (req_word.blue > mx_in) mx_in = req_word.blue;
      mn_in = req_word.red;
      if (req_word.green < mn_in) mn_in = req_word.green;
      if (req_word.blue < mn_in) mn_in = req_word.blue;
      chroma_in = mx_in - mn_in;

      if (mx_in == req_word.red) begin
         sector_in = SECT_RED;
         neg_in    = req_word.green < req_word.blue;
         mag_in    = neg_in ? req_word.blue - req_word.green
                            : req_word.green - req_word.blue;
      end else if (mx_in == req_word.green) begin
         sector_in = SECT_GREEN;
         neg_in    = req_word.blue < req_word.red;
         mag_in    = neg_in ? req_word.red - req_word.blue
                            : req_word.blue - req_word.red;
      end else begin
         sector_in = SECT_BLUE;
         neg_in    = req_word.red < req_word.green;
         mag_in    = neg_in ? req_word.green - req_word.red
                            : req_word.red - req_word.green;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         mx_ff     <= mx_in;
         chroma_ff <= chroma_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
         sector_ff <= sector_in;
      end
   end

   // numerators by shift and subtract; a negative part is rounded up
   assign hue_num = (HUE_NUM_W'(mag_ff) << 12) - (HUE_NUM_W'(mag_ff) << 8)
                  + (neg_ff ? HUE_NUM_W'(chroma_ff) - HUE_NUM_W'(1) : '0);
   assign sat_num = (SAT_NUM_W'(chroma_ff) << 16) - SAT_NUM_W'(chroma_ff);

   rth_divider #(
      .NUM_W (HUE_NUM_W),
      .QUO_W (HUE_QUO_W)
   ) u_hue_div (
      .clock (clock),
      .ctrl  (div_ctrl),
      .num   (hue_num),
      .den   (chroma_ff),
      .quo   (hue_part)
   );

   rth_divider #(
      .NUM_W (SAT_NUM_W),
      .QUO_W (SAT_QUO_W)
   ) u_sat_div (
      .clock (clock),
      .ctrl  (div_ctrl),
      .num   (sat_num),
      .den   (mx_ff),
      .quo   (sat_quo)
   );

   // sector, sign and value ride alongside the dividers
   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[0] <= '{sector: sector_ff, neg: neg_ff, mx: mx_ff};
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (en[k+1]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // hue assembly with wrap below zero
   always_comb begin
      case (side_ff[DIV_STAGES-1].sector)
         SECT_RED:   hue_base = '0;
         SECT_GREEN: hue_base = HUE_GREEN;
         SECT_BLUE:  hue_base = HUE_BLUE;
         default:    hue_base = '0;
      endcase
      if (!side_ff[DIV_STAGES-1].neg) begin
         hue_in = hue_base + HUE_W'(hue_part);
      end else if (hue_base == '0) begin
         hue_in = HUE_FULL - HUE_W'(hue_part);
      end else begin
         hue_in = hue_base - HUE_W'(hue_part);
      end
      rsp_in.hue        = hue_in;
      rsp_in.saturation = sat_quo;
      rsp_in.brightness = side_ff[DIV_STAGES-1].mx;
   end

   // output register
   always_ff @(posedge clock) begin
      if (en[PIPE_STAGES-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_STAGES-1];
   assign rsp_word  = rsp_ff;

`ifndef SYNTHESIS
   // hue stays inside one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.hue < HUE_FULL)
      else $error("hue out of range");

   // a black pixel has no saturation
   a_black_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.brightness == '0) |-> rsp_word.saturation == '0)
      else $error("saturation on black pixel");

   // zero saturation means a grey pixel, whose hue is zero
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.saturation == '0) |-> rsp_word.hue == '0)
      else $error("hue on grey pixel");

   // an accepted word occupies the first stage next cycle
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted word lost at first stage");
`endif

endmodule

FILE: hdl/rth_divider.sv
// ----------------------------------------------------------------------------
// rth_divider: pipelined unsigned divide by an 8-bit divisor
// Reciprocal table lookup, one multiply, back multiply and a single
// correction step. Four register stages; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module rth_divider #(
   parameter int NUM_W = rth_pkg::SAT_NUM_W,
   parameter int QUO_W = rth_pkg::SAT_QUO_W
) (
   input  logic                          clock,
   input  rth_pkg::rth_div_ctrl_type     ctrl,
   input  logic [NUM_W-1:0]              num,
   input  logic [rth_pkg::DIV_W-1:0]     den,
   output logic [QUO_W-1:0]              quo
);
   import rth_pkg::*;

   localparam int RCP_W  = NUM_W + 1;
   localparam int PROD_W = NUM_W + RCP_W;
   localparam int BACK_W = QUO_W + DIV_W;

   // reciprocal table: floor(2^NUM_W / d), zero for d = 0
   logic [RCP_W-1:0] rcp_tab [2**DIV_W];

   for (genvar i = 0; i < 2**DIV_W; i++) begin : g_rcp
      localparam logic [RCP_W-1:0] RCP =
         (i == 0) ? '0 : RCP_W'((64'd1 << NUM_W) / i);
      assign rcp_tab[i] = RCP;
   end

   logic [NUM_W-1:0]  num1_ff, num2_ff, num3_ff;
   logic [DIV_W-1:0]  den1_ff, den2_ff, den3_ff;
   logic [RCP_W-1:0]  rcp1_ff;
   logic [QUO_W-1:0]  q0_2_ff, q0_3_ff;
   logic [BACK_W-1:0] back3_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [PROD_W-1:0] prod;
   logic [NUM_W-1:0]  rem;
   logic              fix;

   // first stage: latch operands and look up the reciprocal
   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         num1_ff <= num;
         den1_ff <= den;
         rcp1_ff <= rcp_tab[den];
      end
   end

   // second stage: estimate, never more than one below the true quotient
   assign prod = PROD_W'(num1_ff) * PROD_W'(rcp1_ff);

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         q0_2_ff <= prod[NUM_W +: QUO_W];
         num2_ff <= num1_ff;
         den2_ff <= den1_ff;
      end
   end

   // third stage: multiply the estimate back
   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         back3_ff <= BACK_W'(q0_2_ff) * BACK_W'(den2_ff);
         q0_3_ff  <= q0_2_ff;
         num3_ff  <= num2_ff;
         den3_ff  <= den2_ff;
      end
   end

   // fourth stage: bump the estimate when the remainder reaches the divisor
   assign rem = num3_ff - NUM_W'(back3_ff);
   assign fix = (den3_ff != '0) && (rem >= NUM_W'(den3_ff));

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         quo_ff <= q0_3_ff + QUO_W'(fix);
      end
   end

   assign quo = quo_ff;

endmodule

FILE: test/rgb_to_hsv_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_test: self-checking bench for the rgb to hsv converter
// Drives pixel words, works out hue, saturation and value for each accepted
// word and checks every result word in order, under several idling patterns.
// ----------------------------------------------------------------------------
module rgb_to_hsv_test;
   import rth_pkg::*;

   // hue scale in 1/64 degree and the saturation full scale
   localparam int SIXTH_UNITS  = 3840;
   localparam int CIRCLE_UNITS = 23040;
   localparam int SAT_FULL     = 65535;
   localparam int REPORT_LIMIT = 10;
   localparam int RANDOM_WORDS = 112;
   localparam int TAIL_CYCLES  = 20;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   rth_req_type req_word  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rth_rsp_type rsp_word;

   rth_rsp_type expected_hsv[$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;

   rgb_to_hsv dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #6 clock = ~clock;

   // hue, saturation and value of one pixel
   function automatic rth_rsp_type predict_hsv(rth_req_type px);
      int             r, g, b, top, bottom, chroma, diff, angle;
      rth_sector_type sector;
      rth_rsp_type    res;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      top = r;
      bottom = r;
      if (g > top) top = g;
      if (b > top) top = b;
      if (g < bottom) bottom = g;
      if (b < bottom) bottom = b;
      chroma = top - bottom;
      res = '0;
      res.brightness = top[CHAN_W-1:0];
      // grey pixels keep hue at zero
      if (chroma != 0) begin
         // red wins ties, then green
         if (top == r) sector = SECT_RED;
         else if (top == g) sector = SECT_GREEN;
         else sector = SECT_BLUE;
         case (sector)
            SECT_RED: begin
               diff = g - b;
               angle = 0;
            end
            SECT_GREEN: begin
               diff = b - r;
               angle = 2 * SIXTH_UNITS;
            end
            default: begin
               diff = r - g;
               angle = 4 * SIXTH_UNITS;
            end
         endcase
         // division floors toward minus infinity
         if (diff >= 0) angle = angle + (SIXTH_UNITS * diff) / chroma;
         else angle = angle - (SIXTH_UNITS * (-diff) + chroma - 1) / chroma;
         if (angle < 0) angle = angle + CIRCLE_UNITS;
         res.hue = angle[HUE_W-1:0];
      end
      // black pixels keep saturation at zero
      if (top != 0) begin
         angle = (chroma * SAT_FULL) / top;
         res.saturation = angle[SAT_W-1:0];
      end
      return res;
   endfunction

   // compare one result word with the oldest expectation
   task automatic check_hsv_word(rth_rsp_type got);
      rth_rsp_type want;
      if (expected_hsv.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: result word with none expected: hue %0d sat %0d val %0d",
                     $realtime, got.hue, got.saturation, got.brightness);
         mismatch_count++;
      end else begin
         want = expected_hsv.pop_front();
         if (got.hue !== want.hue || got.saturation !== want.saturation ||
             got.brightness !== want.brightness) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("%0t: mismatch: hue %0d/%0d sat %0d/%0d val %0d/%0d (exp/got)",
                        $realtime, want.hue, got.hue, want.saturation,
                        got.saturation, want.brightness, got.brightness);
            mismatch_count++;
         end
      end
   endtask

   // result side: check every accepted word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_hsv_word(rsp_word);
   end

   // result side: random stall
   always @(negedge clock) begin
      rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
   end

   // send one pixel word, entered and left at the falling edge
   task automatic send_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
      rth_req_type px;
      px.red = r;
      px.green = g;
      px.blue = b;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_hsv.push_back(predict_hsv(px));
      @(negedge clock);
   endtask

   task automatic set_idling(int send_pct, int stall_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   // drop valid and wait until every expected word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_hsv.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // extremes, every sector, ties, grey and black
   task automatic test_directed_pixels();
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd200, 8'd10,  8'd100);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd1,   8'd1,   8'd0);
      send_pixel(8'd255, 8'd254, 8'd0);
      send_pixel(8'd10,  8'd200, 8'd255);
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd254);
      send_pixel(8'd170, 8'd85,  8'd255);
      drain_results();
   endtask

   // random pixels: mostly uniform, plus ties, greys, corners, near-greys
   task automatic test_random_pixels(int count);
      logic [CHAN_W-1:0] r, g, b;
      int                shape;
      repeat (count) begin
         r = CHAN_W'($urandom_range(255));
         g = CHAN_W'($urandom_range(255));
         b = CHAN_W'($urandom_range(255));
         shape = $urandom_range(9);
         case (shape)
            6: begin
               g = r;
               b = r;
            end
            7: begin
               case ($urandom_range(2))
                  0: g = r;
                  1: b = g;
                  default: b = r;
               endcase
            end
            8: begin
               r = $urandom_range(1) ? 8'd255 : 8'd0;
               g = $urandom_range(1) ? 8'd255 : 8'd0;
               b = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            9: begin
               g = (r > 8'd252) ? r - CHAN_W'($urandom_range(3))
                                : r + CHAN_W'($urandom_range(3));
               b = (r > 8'd252) ? r - CHAN_W'($urandom_range(3))
                                : r + CHAN_W'($urandom_range(3));
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
      drain_results();
   endtask

   // run limit
   initial begin
      #5_000_000;
      $display("rgb_to_hsv_test: errors");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idling(0, 0);
      test_directed_pixels();
      test_random_pixels(RANDOM_WORDS);
      set_idling(77, 0);
      test_random_pixels(RANDOM_WORDS);
      set_idling(0, 77);
      test_random_pixels(RANDOM_WORDS);
      set_idling(19, 19);
      test_random_pixels(RANDOM_WORDS);

      // quiet tail: catch any stray result word
      set_idling(0, 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_hsv.size() == 0)
         $display("rgb_to_hsv_test: clean");
      else
         $display("rgb_to_hsv_test: errors");
      $finish;
   end

endmodule
